[src/ffpa_pkg.sv]
// Shared constants, register codes and state encoding of the page frame allocator.
package ffpa_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 1024;

  localparam int unsigned FRAME_COUNT_W = 11;
  localparam int unsigned PAGE_SHIFT_W  = 5;
  localparam int unsigned COUNT_W       = 11;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 11;

  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 11'd1024;
  localparam logic [PAGE_SHIFT_W-1:0]  PAGE_SHIFT_RST  = 5'd12;
  localparam logic [ADDR_W-1:0]        KSEG_BASE       = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT  = 1'd1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_MARK = 4'b0100,
    ST_FREE = 4'b1000
  } state_t;

endpackage

[src/ffpa_cell.sv]
// One cell of the frame ring: holds the free bit of one frame and passes it on.
module ffpa_cell (
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  logic d,
  output logic q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= 1'b1;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

[src/ffpa_ctrl.sv]
// Head of the frame ring: configuration registers, run search, marking and freeing.
module ffpa_ctrl import ffpa_pkg::*; #(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  op,
  input  logic [COUNT_W-1:0]    page_count,
  input  logic [ADDR_W-1:0]     address,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  head_bit,
  output logic                  ring_in,
  output logic                  shift_en,
  output logic                  busy,
  output logic                  cfg_ready,
  output logic                  done,
  output logic                  ok,
  output logic [ADDR_W-1:0]     result_address
);

  localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  state_t                   state;
  logic [IDX_W-1:0]         pos;
  logic [COUNT_W-1:0]       run;
  logic [IDX_W-1:0]         start_frame;
  logic                     found;
  logic [COUNT_W-1:0]       count;
  logic [ADDR_W-1:0]        first;
  logic [FRAME_COUNT_W-1:0] frame_count;
  logic [PAGE_SHIFT_W-1:0]  page_shift;

  logic              last;
  logic [ADDR_W-1:0] pos_ext;
  logic [ADDR_W-1:0] start_ext;
  logic [ADDR_W-1:0] count_ext;
  logic              in_use;
  logic              scan_live;
  logic              hit;
  logic              in_mark;
  logic              in_free;

  assign busy      = (state != ST_IDLE);
  assign shift_en  = busy;
  assign cfg_ready = !busy && !start;

  assign last      = (pos == IDX_W'(MAX_FRAMES - 1));
  assign pos_ext   = ADDR_W'(pos);
  assign start_ext = ADDR_W'(start_frame);
  assign count_ext = ADDR_W'(count);
  assign in_use    = pos_ext < ADDR_W'(frame_count);

  assign scan_live = !found && (count != '0) && in_use;
  assign hit       = scan_live && head_bit && ((run + 11'd1) == count);
  assign in_mark   = (pos_ext >= start_ext) && ((pos_ext - start_ext) < count_ext);
  assign in_free   = in_use && (pos_ext >= first) && ((pos_ext - first) < count_ext);

  always_comb begin
    case (state)
      ST_MARK: ring_in = head_bit & !in_mark;
      ST_FREE: ring_in = head_bit | in_free;
      default: ring_in = head_bit;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      frame_count <= FRAME_COUNT_RST;
      page_shift  <= PAGE_SHIFT_RST;
    end else begin
      done <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_COUNT: frame_count <= cfg_data[FRAME_COUNT_W-1:0];
          REG_PAGE_SHIFT:  page_shift  <= cfg_data[PAGE_SHIFT_W-1:0];
          default: ;
        endcase
      end

      if (busy) begin
        pos <= last ? '0 : pos + IDX_W'(1);
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            count <= page_count;
            first <= (address - KSEG_BASE) >> page_shift;
            pos   <= '0;
            run   <= '0;
            found <= 1'b0;
            state <= (op == OP_FREE) ? ST_FREE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_live) begin
            if (head_bit) begin
              if (run == '0) begin
                start_frame <= pos;
              end
              run <= run + 11'd1;
              if (hit) begin
                found <= 1'b1;
              end
            end else begin
              run <= '0;
            end
          end
          if (last) begin
            if (found || hit) begin
              state <= ST_MARK;
            end else begin
              done           <= 1'b1;
              ok             <= 1'b0;
              result_address <= '0;
              state          <= ST_IDLE;
            end
          end
        end
        ST_MARK: begin
          if (last) begin
            done           <= 1'b1;
            ok             <= 1'b1;
            result_address <= (start_ext << page_shift) + KSEG_BASE;
            state          <= ST_IDLE;
          end
        end
        ST_FREE: begin
          if (last) begin
            done           <= 1'b1;
            ok             <= 1'b1;
            result_address <= '0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/first_fit_page_frame_allocator_unit.sv]
// Top level of the first-fit page frame allocator: frame ring and its head.
//
//   channel   signals                                   transfer when
//   command   start, op, page_count, address / busy     start & !busy
//   result    done, ok, result_address                  done (one cycle)
//   config    cfg_valid, cfg_index, cfg_data / ready    cfg_valid & cfg_ready
//
// The free bits rotate through a ring of MAX_FRAMES cells, one frame per cycle past the head
// while a command runs. A free walks the ring once, an allocation once to search and again
// to mark the run when one is found; the result appears in the cycle after the last frame.
// Reset marks every frame free and loads the default registers at once.
// Configuration transfers are taken only while no command is running or being started.
// The result strobe lasts one cycle and cannot be held off.
module first_fit_page_frame_allocator_unit import ffpa_pkg::*; #(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  op,
  input  logic [COUNT_W-1:0]    page_count,
  input  logic [ADDR_W-1:0]     address,
  output logic                  done,
  output logic                  ok,
  output logic [ADDR_W-1:0]     result_address,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MAX_FRAMES-1:0] q;
  logic                  ring_in;
  logic                  shift_en;

  ffpa_ctrl #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .op             (op),
    .page_count     (page_count),
    .address        (address),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .head_bit       (q[0]),
    .ring_in        (ring_in),
    .shift_en       (shift_en),
    .busy           (busy),
    .cfg_ready      (cfg_ready),
    .done           (done),
    .ok             (ok),
    .result_address (result_address)
  );

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    if (i == MAX_FRAMES - 1) begin : g_tail
      ffpa_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift_en),
        .d     (ring_in),
        .q     (q[i])
      );
    end else begin : g_body
      ffpa_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift_en),
        .d     (q[i+1]),
        .q     (q[i])
      );
    end
  end

endmodule

[src/ffpa_checker.sv]
// Port-level checks of the page frame allocator and their binding to the top level.
module ffpa_checker import ffpa_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic                  ok,
  input logic [ADDR_W-1:0]     result_address,
  input logic                  cfg_valid,
  input logic                  cfg_ready
);

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("Result strobe without a running command.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result strobe while a command is still running.");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("Accepted command did not start.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (result_address == '0))
    else $error("Failed allocation returned a nonzero address.");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && busy) |-> !cfg_ready)
    else $error("Configuration transfer taken while busy.");

endmodule

bind first_fit_page_frame_allocator_unit ffpa_checker u_ffpa_checker (.*);
